[rtl/bis_pkg.sv]
// bis_pkg: shared types for the binary insertion sorter
package bis_pkg;

	// sequencer states, one-hot
	typedef enum logic [1:0] {
		ST_FILL  = 2'b01,
		ST_DRAIN = 2'b10
	} bis_state_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;   // place the broadcast value into the chain
		logic shift; // move every entry one place toward cell zero
	} bis_cmd_t;

endpackage

[rtl/binary_insertion_sorter.sv]
// binary_insertion_sorter: sorting chain of compare-and-shift cells with batch drain
// Fill: one value accepted per cycle; cells compare and larger ones shift in that same cycle.
// A batch of stored values then drains one result per cycle while res_stall is low, starting
// the cycle after the last item; input is stalled while the chain drains.
// Values past DEPTH in a batch are dropped and flagged.
// Reset (arst_n low, asynchronous) empties the chain and clears the drop flag.
module binary_insertion_sorter import bis_pkg::*; #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   last,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic [VALUE_WIDTH-1:0] sorted_value,
	output logic                   final_res,
	output logic                   overflow
);

	bis_state_t               state_q;
	bis_cmd_t                 cmd;
	logic                     dropped_q;
	logic                     item_xfer;
	logic                     res_xfer;
	logic                     full;
	logic [DEPTH-1:0]         occ_vec;
	logic [DEPTH-1:0]         gt_vec;
	logic [VALUE_WIDTH-1:0]   val_arr [DEPTH];

	// handshake
	assign item_stall = (state_q != ST_FILL);
	assign item_xfer  = item_valid && !item_stall;
	assign res_valid  = (state_q == ST_DRAIN) && occ_vec[0];
	assign res_xfer   = res_valid && !res_stall;
	assign full       = occ_vec[DEPTH-1];

	// chain commands
	assign cmd.ins   = item_xfer && !full;
	assign cmd.shift = res_xfer;

	// result value comes straight from the head cell, final_res from the first two cells
	assign sorted_value = val_arr[0];
	assign final_res    = occ_vec[0] && !occ_vec[1];
	assign overflow     = dropped_q;

	// the chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] lval;
		logic                   locc;
		logic                   lgt;
		logic [VALUE_WIDTH-1:0] rval;
		logic                   rocc;

		if (i == 0) begin : g_head
			assign lval = '0;
			assign locc = 1'b0;
			assign lgt  = 1'b0;
		end else begin : g_body
			assign lval = val_arr[i-1];
			assign locc = occ_vec[i-1];
			assign lgt  = gt_vec[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign rval = '0;
			assign rocc = 1'b0;
		end else begin : g_mid
			assign rval = val_arr[i+1];
			assign rocc = occ_vec[i+1];
		end

		bis_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.new_value  (value),
			.left_value (lval),
			.left_occ   (locc),
			.left_gt    (lgt),
			.right_value(rval),
			.right_occ  (rocc),
			.value_q    (val_arr[i]),
			.occ_q      (occ_vec[i]),
			.gt         (gt_vec[i])
		);
	end

	// batch sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (item_xfer && last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (res_xfer && final_res) begin
						state_q <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	// drop flag for the current batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q <= 1'b0;
		end else if (res_xfer && final_res) begin
			dropped_q <= 1'b0;
		end else if (item_xfer && full) begin
			dropped_q <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	// occupied cells always form a run from cell zero
	a_occ_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_vec + 1'b1) & occ_vec) == '0)
		else $error("occupied cells not contiguous");

	// the chain is never empty while draining
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> occ_vec[0])
		else $error("drain with empty chain");

	// the final transfer leaves the chain empty
	a_final_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(res_xfer && final_res) |=> (occ_vec == '0))
		else $error("chain not empty after batch");

	// an insert grows occupancy by exactly one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> ($countones(occ_vec) == $past($countones(occ_vec)) + 1))
		else $error("insert did not add one entry");

	// a drop is only flagged when the chain was full
	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dropped_q) |-> $past(full))
		else $error("drop flagged without full chain");
`endif

endmodule

[rtl/bis_cell.sv]
// bis_cell: one compare-and-shift cell of the sorting chain
module bis_cell import bis_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bis_cmd_t               cmd,
	input  logic [VALUE_WIDTH-1:0] new_value,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic                   left_occ,
	input  logic                   left_gt,
	input  logic [VALUE_WIDTH-1:0] right_value,
	input  logic                   right_occ,
	output logic [VALUE_WIDTH-1:0] value_q,
	output logic                   occ_q,
	output logic                   gt
);

	// an empty cell counts as larger than any value
	assign gt = !occ_q || ($signed(value_q) > $signed(new_value));

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.shift) begin
			occ_q <= right_occ;
		end else if (cmd.ins && gt) begin
			occ_q <= left_gt ? left_occ : 1'b1;
		end
	end

	// stored value
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			value_q <= right_value;
		end else if (cmd.ins && gt) begin
			value_q <= left_gt ? left_value : new_value;
		end
	end

endmodule
